>>> rtl/mbc_pkg.sv
// Shared types and constants for the maze backtracker carver.
// No dependencies; imported by the top level, mbc_checker and the testbench.
package mbc_pkg;

  localparam int OUT_W   = 6;   // wall index port width
  localparam int CFG_W   = 6;   // grid size register width
  localparam int EPOCH_W = 4;   // visited tag width; tag zero never marks a cell

  localparam logic [CFG_W-1:0] GRID_RESET = 6'd16;

  // Result status codes
  localparam logic [1:0] STAT_CARVED  = 2'd0;
  localparam logic [1:0] STAT_REJECT  = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_STARTED = 2'd3;

  // Input function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DRAW  = 1'b1;

  // Direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK,
    S_PROBE,
    S_EVAL,
    S_POP
  } state_t;

endpackage

>>> rtl/mbc_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies; used for the visited tags and the backtrack stack.
module mbc_ram #(
  parameter int W     = 4,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/maze_backtracker_carver_top.sv
// Top level of the depth-first maze carver: control FSM, cell datapath,
// visited-tag RAM and backtrack-stack RAM. Depends on mbc_pkg and mbc_ram.
//
//  channel   | ports                                   | transfer
//  ----------+-----------------------------------------+-----------------------------
//  command   | start, busy, func, draw                 | start & !busy at clk edge
//  result    | done, status, wall_horizontal,          | done high one cycle, no stall
//            | wall_row, wall_col, complete            |
//  config    | cfg_write, cfg_data                     | cfg_write at clk edge
//
// Steps: a start goes through S_MARK to its result; the 16th start after reset, and
// every 15th start after that, first sweeps the whole visited RAM (2^(2*clog2(MAX_SIDE))
// entries, 1024 at the default). A draw on a finished maze answers in the next cycle
// without raising busy. Any other draw runs neighbor probes, each an S_PROBE then an
// S_EVAL step (one visited-RAM read each, 1 to 4 probes per cell), with an S_POP step
// per popped stack entry, which restarts the probes, before the result strobe.
// Reset (rst, synchronous) runs a clearing pass over the visited RAM with busy
// high; config writes are taken during it. Results cannot be stalled.
module maze_backtracker_carver_top
  import mbc_pkg::*;
#(
  parameter int MAX_SIDE = 32
) (
  input  logic             clk,
  input  logic             rst,
  // command transaction
  input  logic             start,
  output logic             busy,
  input  logic             func,
  input  logic [1:0]       draw,
  // result transaction
  output logic             done,
  output logic [1:0]       status,
  output logic             wall_horizontal,
  output logic [OUT_W-1:0] wall_row,
  output logic [OUT_W-1:0] wall_col,
  output logic             complete,
  // configuration
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int RW    = $clog2(MAX_SIDE);        // row / column index width
  localparam int NW    = $clog2(MAX_SIDE + 1);    // side length width
  localparam int XW    = NW + 1;                  // neighbor coordinate width
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int SAW   = $clog2(CELLS);           // stack address width
  localparam int DW    = $clog2(CELLS + 1);       // stack depth width
  localparam int CLW   = $clog2(CELLS);           // remaining-cells width
  localparam int VAW   = 2 * RW;                  // visited RAM address {row, col}
  localparam int WX    = (XW > OUT_W) ? XW : OUT_W;

  localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t             state, state_next;
  logic [CFG_W-1:0]   grid_size;
  logic [EPOCH_W-1:0] epoch;
  logic [VAW-1:0]     clr_addr;
  logic               clr_for_start;   // sweep was forced by a start
  logic [RW-1:0]      cur_row, cur_col;
  logic [DW-1:0]      stack_depth;
  logic [CLW-1:0]     cells_left;
  logic [1:0]         draw_r;
  logic [1:0]         probe_cnt;
  logic [RW-1:0]      tgt_row, tgt_col;
  logic               tgt_in;

  // --------------------------------------------------------------------------
  // Effective side length and starting cell count
  // --------------------------------------------------------------------------
  logic [NW-1:0]   side_n;
  logic [XW-1:0]   side_x;
  logic [2*NW-1:0] side_sq;
  logic [CLW-1:0]  cells_init;

  always_comb begin
    if (grid_size == '0) begin
      side_n = NW'(1);
    end else if (int'(grid_size) > MAX_SIDE) begin
      side_n = NW'(MAX_SIDE);
    end else begin
      side_n = NW'(grid_size);
    end
  end

  assign side_x     = XW'(side_n);
  assign side_sq    = (2*NW)'(side_n) * (2*NW)'(side_n);
  assign cells_init = CLW'(side_sq - (2*NW)'(1));

  // --------------------------------------------------------------------------
  // Neighbor target of the probe direction; probe order starts at the draw
  // --------------------------------------------------------------------------
  logic [1:0]    probe_dir;
  logic [XW-1:0] tr_x, tc_x;
  logic          probe_in;

  assign probe_dir = draw_r + probe_cnt;

  always_comb begin
    tr_x     = XW'(cur_row);
    tc_x     = XW'(cur_col);
    probe_in = 1'b1;
    unique case (probe_dir)
      DIR_UP: begin
        probe_in = (cur_row != '0);
        tr_x     = XW'(cur_row) - XW'(1);
      end
      DIR_DOWN: begin
        tr_x = XW'(cur_row) + XW'(1);
      end
      DIR_LEFT: begin
        probe_in = (cur_col != '0);
        tc_x     = XW'(cur_col) - XW'(1);
      end
      DIR_RIGHT: begin
        tc_x = XW'(cur_col) + XW'(1);
      end
      default: ;
    endcase
    probe_in = probe_in && (tr_x < side_x) && (tc_x < side_x);
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic               vis_we;
  logic [VAW-1:0]     vis_waddr;
  logic [EPOCH_W-1:0] vis_wdata;
  logic [VAW-1:0]     vis_raddr;
  logic [EPOCH_W-1:0] vis_rdata;

  logic               stk_we;
  logic [SAW-1:0]     stk_raddr;
  logic [VAW-1:0]     stk_rdata;

  assign vis_raddr = {tr_x[RW-1:0], tc_x[RW-1:0]};
  assign stk_raddr = SAW'(stack_depth - DW'(1));

  mbc_ram #(.W(EPOCH_W), .DEPTH(1 << VAW)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  mbc_ram #(.W(VAW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_depth[SAW-1:0]),
    .wdata ({cur_row, cur_col}),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // --------------------------------------------------------------------------
  // Probe evaluation: a cell is visited when its tag equals the current epoch
  // --------------------------------------------------------------------------
  logic probe_free;
  logic do_carve, do_reject, do_pop, do_next;
  logic accept;

  assign accept     = start && !busy;
  assign probe_free = tgt_in && (vis_rdata != epoch);

  always_comb begin
    do_carve  = 1'b0;
    do_reject = 1'b0;
    do_pop    = 1'b0;
    do_next   = 1'b0;
    if (state == S_EVAL) begin
      priority if (probe_free && probe_cnt == '0) begin
        do_carve = 1'b1;
      end else if (probe_free) begin
        do_reject = 1'b1;                  // a neighbor is free, the drawn one is not
      end else if (probe_cnt != 2'd3) begin
        do_next = 1'b1;
      end else if (stack_depth != '0) begin
        do_pop = 1'b1;                     // dead end: back up one cell
      end else begin
        do_reject = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // FSM: next state and memory write controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    vis_we     = 1'b0;
    vis_waddr  = clr_addr;
    vis_wdata  = '0;
    stk_we     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        vis_we = 1'b1;
        if (&clr_addr) begin
          state_next = clr_for_start ? S_MARK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && func == FUNC_START) begin
          state_next = (epoch == EPOCH_LAST) ? S_CLEAR : S_MARK;
        end else if (accept && cells_left != '0) begin
          state_next = S_PROBE;
        end
      end
      S_MARK: begin
        vis_we     = 1'b1;
        vis_waddr  = '0;
        vis_wdata  = epoch;
        state_next = S_IDLE;
      end
      S_PROBE: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        priority if (do_carve) begin
          vis_we     = 1'b1;
          vis_waddr  = {tgt_row, tgt_col};
          vis_wdata  = epoch;
          stk_we     = (int'(stack_depth) < CELLS);
          state_next = S_IDLE;
        end else if (do_reject) begin
          state_next = S_IDLE;
        end else if (do_next) begin
          state_next = S_PROBE;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        state_next = S_PROBE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // Wall report for a carve (current cell before the move)
  // --------------------------------------------------------------------------
  logic [WX-1:0] wrow_x, wcol_x;

  always_comb begin
    wrow_x = WX'(cur_row);
    wcol_x = WX'(cur_col);
    if (draw_r == DIR_RIGHT) begin
      wcol_x = WX'(cur_col) + WX'(1);
    end else if (draw_r == DIR_DOWN) begin
      wrow_x = WX'(cur_row) + WX'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
    end else if (cfg_write) begin
      grid_size <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // Control and cell datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch         <= '0;
      clr_addr      <= '0;
      clr_for_start <= 1'b0;
      cur_row       <= '0;
      cur_col       <= '0;
      stack_depth   <= '0;
      cells_left    <= '0;
      probe_cnt     <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + VAW'(1);
        end
        S_IDLE: begin
          if (accept && func == FUNC_START) begin
            cells_left  <= cells_init;
            cur_row     <= '0;
            cur_col     <= '0;
            stack_depth <= '0;
            if (epoch == EPOCH_LAST) begin
              epoch         <= EPOCH_W'(1);
              clr_addr      <= '0;
              clr_for_start <= 1'b1;
            end else begin
              epoch <= epoch + EPOCH_W'(1);
            end
          end else if (accept && cells_left != '0) begin
            probe_cnt <= '0;
          end else if (accept) begin
            done <= 1'b1;                  // maze already complete
          end
        end
        S_MARK: begin
          clr_for_start <= 1'b0;
          done          <= 1'b1;
        end
        S_PROBE: ;
        S_EVAL: begin
          if (do_carve) begin
            if (int'(stack_depth) < CELLS) begin
              stack_depth <= stack_depth + DW'(1);
            end
            cur_row    <= tgt_row;
            cur_col    <= tgt_col;
            cells_left <= cells_left - CLW'(1);
            done       <= 1'b1;
          end else if (do_reject) begin
            done <= 1'b1;
          end else if (do_next) begin
            probe_cnt <= probe_cnt + 2'd1;
          end else if (do_pop) begin
            stack_depth <= stack_depth - DW'(1);
          end
        end
        S_POP: begin
          cur_row   <= stk_rdata[VAW-1:RW];
          cur_col   <= stk_rdata[RW-1:0];
          probe_cnt <= '0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers: draw latch, probe target, result fields
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      draw_r <= draw;
    end
    if (state == S_PROBE) begin
      tgt_row <= tr_x[RW-1:0];
      tgt_col <= tc_x[RW-1:0];
      tgt_in  <= probe_in;
    end

    wall_horizontal <= 1'b0;
    wall_row        <= '0;
    wall_col        <= '0;
    unique case (state)
      S_IDLE: begin
        status   <= STAT_FULL;
        complete <= 1'b1;
      end
      S_MARK: begin
        status   <= STAT_STARTED;
        complete <= (cells_left == '0);
      end
      S_EVAL: begin
        if (do_carve) begin
          status          <= STAT_CARVED;
          wall_horizontal <= draw_r[1];
          wall_row        <= wrow_x[OUT_W-1:0];
          wall_col        <= wcol_x[OUT_W-1:0];
          complete        <= (cells_left == CLW'(1));
        end else begin
          status   <= STAT_REJECT;
          complete <= (cells_left == '0);
        end
      end
      default: begin
        status   <= STAT_REJECT;
        complete <= 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/mbc_checker.sv
// Port-level checks for the maze backtracker carver, bound to the top level.
// Depends on mbc_pkg for the status codes.
module mbc_checker
  import mbc_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [1:0]       status,
  input logic             wall_horizontal,
  input logic [OUT_W-1:0] wall_row,
  input logic [OUT_W-1:0] wall_col,
  input logic             complete
);

  // Only a carve reports a wall
  a_wall_only_on_carve: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_CARVED) |->
      (!wall_horizontal && wall_row == '0 && wall_col == '0))
    else $error("wall fields set on a non-carve result");

  // A draw on a finished maze reports it finished
  a_full_is_complete: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |-> complete)
    else $error("full status without complete");

  // A rejected draw leaves cells to visit
  a_reject_not_complete: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_REJECT) |-> !complete)
    else $error("reject status with complete");

  // Busy rises only on an accepted command transaction
  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // A result is only presented once the block is back to idle
  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

endmodule

bind maze_backtracker_carver_top mbc_checker u_mbc_checker (.*);

>>> test/maze_carve_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the maze carver: mirrors carve state, predicts each result.
// Depends on mbc_pkg; sits beside the dut in maze_backtracker_carver_top_test.
module maze_carve_checker
  import mbc_pkg::*;
#(
  parameter int MAX_SIDE = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             func,
  input  logic [1:0]       draw,
  input  logic             done,
  input  logic [1:0]       status,
  input  logic             wall_horizontal,
  input  logic [OUT_W-1:0] wall_row,
  input  logic [OUT_W-1:0] wall_col,
  input  logic             complete,
  input  logic             cfg_write,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             end_of_test,
  output int               fail_count,
  output int               pending
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int POS_W = $clog2(MAX_SIDE);

  typedef struct packed {
    logic [1:0]       status;
    logic             horizontal;
    logic [OUT_W-1:0] wall_row;
    logic [OUT_W-1:0] wall_col;
    logic             complete;
  } carve_result_t;

  // mirrored block state
  logic [CFG_W-1:0] side_reg;
  logic             visited [CELLS];
  logic [CELL_W-1:0] trail [CELLS];
  logic [CELL_W:0]  trail_depth;
  logic [POS_W-1:0] cur_row;
  logic [POS_W-1:0] cur_col;
  logic [CELL_W-1:0] cells_left;

  carve_result_t carve_queue[$];
  int mismatches = 0;

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned side_len();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return int'(side_reg);
  endfunction

  // target cell of a move; 0 when it leaves the grid
  function automatic bit step_target(input int unsigned r, input int unsigned c,
                                     input logic [1:0] dir, input int unsigned n,
                                     output int unsigned tr, output int unsigned tc);
    tr = r;
    tc = c;
    case (dir)
      DIR_UP: begin
        if (r == 0) return 1'b0;
        tr = r - 1;
      end
      DIR_DOWN: tr = r + 1;
      DIR_LEFT: begin
        if (c == 0) return 1'b0;
        tc = c - 1;
      end
      default: tc = c + 1;
    endcase
    return (tr < n) && (tc < n);
  endfunction

  function automatic bit cell_open(input int unsigned r, input int unsigned c,
                                   input logic [1:0] dir, input int unsigned n);
    int unsigned tr;
    int unsigned tc;
    if (!step_target(r, c, dir, n, tr, tc)) return 1'b0;
    return !visited[tr * MAX_SIDE + tc];
  endfunction

  function automatic bit any_open(input int unsigned n);
    for (int d = 0; d < 4; d++)
      if (cell_open(cur_row, cur_col, 2'(d), n)) return 1'b1;
    return 1'b0;
  endfunction

  // one command: updates the mirrored state, returns the expected result
  function automatic carve_result_t carve_step(input logic f, input logic [1:0] dir);
    carve_result_t r;
    int unsigned n;
    int unsigned tr;
    int unsigned tc;
    logic [CELL_W-1:0] e;
    r = '0;
    n = side_len();
    if (f == FUNC_START) begin
      foreach (visited[i]) visited[i] = 1'b0;
      visited[0] = 1'b1;
      trail_depth = '0;
      cur_row = '0;
      cur_col = '0;
      cells_left = CELL_W'(n * n - 1);
      r.status = STAT_STARTED;
    end else if (cells_left == 0) begin
      r.status = STAT_FULL;
    end else begin
      // back up until some neighbor is still unvisited
      while (!any_open(n) && trail_depth != 0) begin
        trail_depth--;
        e = trail[trail_depth];
        cur_row = POS_W'((e / MAX_SIDE) % MAX_SIDE);
        cur_col = POS_W'(e % MAX_SIDE);
      end
      if (!cell_open(cur_row, cur_col, dir, n)) begin
        r.status = STAT_REJECT;
      end else begin
        void'(step_target(cur_row, cur_col, dir, n, tr, tc));
        if (dir == DIR_LEFT || dir == DIR_RIGHT) begin
          r.horizontal = 1'b1;
          r.wall_row = OUT_W'(cur_row);
          r.wall_col = (dir == DIR_RIGHT) ? OUT_W'(cur_col + 1) : OUT_W'(cur_col);
        end else begin
          r.wall_row = (dir == DIR_DOWN) ? OUT_W'(cur_row + 1) : OUT_W'(cur_row);
          r.wall_col = OUT_W'(cur_col);
        end
        if (trail_depth < CELLS) begin
          trail[trail_depth] = CELL_W'(cur_row * MAX_SIDE + cur_col);
          trail_depth++;
        end
        cur_row = POS_W'(tr);
        cur_col = POS_W'(tc);
        visited[tr * MAX_SIDE + tc] = 1'b1;
        cells_left--;
        r.status = STAT_CARVED;
      end
    end
    r.complete = (cells_left == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    carve_result_t want;
    if (rst) begin
      side_reg = GRID_RESET;
      foreach (visited[i]) visited[i] = 1'b0;
      trail_depth = '0;
      cur_row = '0;
      cur_col = '0;
      cells_left = '0;
      carve_queue.delete();
    end else begin
      // results first: a command taken at this edge cannot have answered yet
      if (done) begin
        if (carve_queue.size() == 0) begin
          note_mismatch($sformatf("result with nothing outstanding, status %0d", status));
        end else begin
          want = carve_queue.pop_front();
          if (status !== want.status)
            note_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (wall_horizontal !== want.horizontal)
            note_mismatch($sformatf("wall_horizontal %0d, expected %0d",
                                    wall_horizontal, want.horizontal));
          if (wall_row !== want.wall_row)
            note_mismatch($sformatf("wall_row %0d, expected %0d", wall_row, want.wall_row));
          if (wall_col !== want.wall_col)
            note_mismatch($sformatf("wall_col %0d, expected %0d", wall_col, want.wall_col));
          if (complete !== want.complete)
            note_mismatch($sformatf("complete %0d, expected %0d", complete, want.complete));
        end
      end
      if (cfg_write) side_reg = cfg_data;
      if (start && !busy) carve_queue.insert(carve_queue.size(), carve_step(func, draw));
      if (end_of_test && carve_queue.size() != 0)
        note_mismatch($sformatf("%0d results never arrived", carve_queue.size()));
    end
    // published with NBA so the stimulus side reads settled values
    pending <= carve_queue.size();
    fail_count <= mismatches;
  end

endmodule

>>> test/maze_backtracker_carver_top_test.sv
`timescale 1ns / 100ps
// Top of the maze carver testbench: clock, reset, command and config stimulus.
// Depends on mbc_pkg, maze_backtracker_carver_top and maze_carve_checker.
module maze_backtracker_carver_top_test
  import mbc_pkg::*;
();

  localparam int MAX_SIDE = 32;
  // watchdog limit, with a wide margin over the slowest legal run
  localparam int LIMIT = 400000;
  // tail after the last result: covers a clearing sweep of the visited RAM
  localparam int TAIL_CYCLES = 1100;
  localparam int RANDOM_ITEMS = 850;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             func = FUNC_START;
  logic [1:0]       draw = DIR_UP;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             end_of_test = 1'b0;

  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic             wall_horizontal;
  logic [OUT_W-1:0] wall_row;
  logic [OUT_W-1:0] wall_col;
  logic             complete;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent = 0;       // commands accepted so far
  bit steady = 1'b0;  // when set, issue() adds no random idle cycles

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  maze_backtracker_carver_top #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .draw(draw),
    .done(done),
    .status(status),
    .wall_horizontal(wall_horizontal),
    .wall_row(wall_row),
    .wall_col(wall_col),
    .complete(complete),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  maze_carve_checker #(
    .MAX_SIDE(MAX_SIDE)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .draw(draw),
    .done(done),
    .status(status),
    .wall_horizontal(wall_horizontal),
    .wall_row(wall_row),
    .wall_col(wall_col),
    .complete(complete),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .end_of_test(end_of_test),
    .fail_count(fail_count),
    .pending(pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One command transaction. Returns in the time step of the accepting edge
  // with start still high, so a back-to-back command only re-drives the data
  // and start never sees two NBAs in one step. Random idle cycles go first;
  // they land on whatever phase the block is in at that moment.
  task automatic issue(input logic f, input logic [1:0] d);
    while (!steady && $urandom_range(0, 99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    draw <= d;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Register write only once the block is idle and every result is in.
  // pending and busy are both sampled pre-edge, so they describe the same cycle.
  task automatic set_grid(input logic [CFG_W-1:0] side);
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    cfg_write <= 1'b1;
    cfg_data <= side;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int pick;
    int side;
    int eff;
    int draws;
    int reshape_at;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // draw straight out of reset: no maze yet, so it reports a finished maze
    issue(FUNC_DRAW, DIR_UP);

    // 3x3 walk that runs into a dead end at (1,0); the next draw must back up
    // two cells to (2,1) and is then rejected against visited (1,1)
    set_grid(6'd3);
    issue(FUNC_START, DIR_DOWN);
    issue(FUNC_DRAW, DIR_LEFT);   // off the grid
    issue(FUNC_DRAW, DIR_RIGHT);
    issue(FUNC_DRAW, DIR_DOWN);
    issue(FUNC_DRAW, DIR_DOWN);
    issue(FUNC_DRAW, DIR_LEFT);
    issue(FUNC_DRAW, DIR_UP);     // dead end reached
    issue(FUNC_DRAW, DIR_UP);     // backtrack, then reject; pops stay
    issue(FUNC_DRAW, DIR_RIGHT);
    issue(FUNC_DRAW, DIR_UP);
    issue(FUNC_DRAW, DIR_UP);     // last cell: maze complete
    issue(FUNC_DRAW, DIR_DOWN);   // draw on a finished maze

    // size zero behaves as a single cell: complete right at start
    set_grid(6'd0);
    issue(FUNC_START, DIR_RIGHT);
    issue(FUNC_DRAW, DIR_RIGHT);

    // all-ones size saturates to the largest grid
    set_grid(6'd63);
    issue(FUNC_START, DIR_UP);
    issue(FUNC_DRAW, DIR_RIGHT);
    issue(FUNC_DRAW, DIR_DOWN);

    // shrink mid-maze to one cell: empty stack and no open neighbor -> reject;
    // grow again and the same maze carries on with the old remaining count
    set_grid(6'd5);
    issue(FUNC_START, DIR_LEFT);
    set_grid(6'd1);
    issue(FUNC_DRAW, DIR_RIGHT);
    set_grid(6'd2);
    issue(FUNC_DRAW, DIR_RIGHT);

    // ---- random part: mostly full mazes on small grids ----
    while (sent < 21 + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) side = $urandom_range(1, 6);
      else if (pick < 80) side = $urandom_range(7, 12);
      else if (pick < 88) side = $urandom_range(13, 31);
      else if (pick < 93) side = 32;
      else if (pick < 96) side = 0;
      else side = $urandom_range(33, 63);
      eff = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
      // small grids get enough draws to finish and then some;
      // big ones are only carved partway
      if (eff <= 6) draws = $urandom_range(eff * eff * 3, eff * eff * 4 + 4);
      else if (eff <= 12) draws = $urandom_range(40, 120);
      else draws = $urandom_range(20, 80);
      reshape_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, draws) : -1;

      set_grid(CFG_W'(side));
      issue(FUNC_START, 2'($urandom_range(0, 3)));
      for (int k = 0; k < draws && sent < 21 + RANDOM_ITEMS; k++) begin
        // a stretch of the run with back-to-back commands
        steady = (sent >= 400 && sent < 560);
        if (k == reshape_at) set_grid(CFG_W'($urandom_range(0, 40)));
        if ($urandom_range(0, 39) == 0)
          issue(FUNC_START, 2'($urandom_range(0, 3)));  // restart mid-maze
        else
          issue(FUNC_DRAW, 2'($urandom_range(0, 3)));
      end
    end

    // ---- drain and verdict ----
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    end_of_test <= 1'b1;
    @(posedge clk);
    end_of_test <= 1'b0;
    @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mbc_pkg.sv
rtl/mbc_ram.sv
rtl/maze_backtracker_carver_top.sv
rtl/mbc_checker.sv
test/maze_carve_checker.sv
test/maze_backtracker_carver_top_test.sv
